@@ rtl/yenc_dec_pkg.sv @@
package yenc_dec_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } enc_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        verdict_valid;
        logic        crc_ok;
        logic [31:0] computed_crc;
        logic        last_of_run;
    } dec_word_t;

    localparam logic [7:0]  BYTE_LF     = 8'h0a;
    localparam logic [7:0]  BYTE_CR     = 8'h0d;
    localparam logic [7:0]  BYTE_ESC    = 8'h3d;
    localparam logic [7:0]  OFFSET_BASE = 8'd42;
    localparam logic [7:0]  OFFSET_ESC  = 8'd64;
    localparam logic [31:0] CRC_POLY    = 32'hedb88320;
    localparam logic [31:0] CRC_INIT    = 32'hffffffff;

    localparam int BEGIN_LEN = 8;
    localparam int END_LEN   = 6;
    localparam int TAG_LEN   = 6;

    // Characters of the header line tag "=ybegin ".
    function automatic logic [7:0] begin_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3d;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h62;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h67;
            3'd5:    c = 8'h69;
            3'd6:    c = 8'h6e;
            3'd7:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of the trailer line tag "=yend ".
    function automatic logic [7:0] end_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3d;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h6e;
            3'd4:    c = 8'h64;
            3'd5:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of the trailer keyword "crc32=".
    function automatic logic [7:0] crc_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h63;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h63;
            3'd3:    c = 8'h33;
            3'd4:    c = 8'h32;
            3'd5:    c = 8'h3d;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] decode_byte(input logic [7:0] x, input logic esc);
        logic [7:0] v;
        v = esc ? (x - OFFSET_ESC - OFFSET_BASE) : (x - OFFSET_BASE);
        return v;
    endfunction

    // Decoded bytes of a held line prefix that turned out not to be a trailer tag.
    // The leading '=' escapes the second character.
    function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
        logic [7:0] v;
        v = decode_byte(end_char(idx + 3'd1), idx == 3'd0);
        return v;
    endfunction

    // Returns a valid flag above the 4-bit digit value.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/yenc_stream_decoder.sv @@
// The results of an input word are held in pending registers, then pass through the output register.
// Throughput: one input word per cycle while each word yields at most one result and
// dec_stall stays low; a word with more results holds the input side until its last one
// is popped, its results draining one per cycle through the output register when it is not stalled, updating the CRC.
// Reset: all line and trailer state is cleared, the CRC is preset to all ones, and
// the block waits for a begin line; there is no memory and no clearing pass.
module yenc_stream_decoder (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    enc_valid,
    output logic                    enc_stall,
    input  yenc_dec_pkg::enc_word_t enc_word,
    output logic                    dec_valid,
    input  logic                    dec_stall,
    output yenc_dec_pkg::dec_word_t dec_word
);
    import yenc_dec_pkg::*;

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_BODY,
        PH_TRAIL,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  lmc_reg, lmc_next;
    logic        skip_reg, skip_next;
    logic        esc_reg, esc_next;
    logic        cr_reg, cr_next;
    logic [31:0] exp_reg, exp_next;
    logic [2:0]  tmc_reg, tmc_next;
    logic [3:0]  hdc_reg, hdc_next;
    logic [31:0] crc_reg;

    // Pending results of the current word: prefix bytes, up to two bytes, a verdict.
    logic [2:0]  pidx_reg;
    logic [2:0]  pcnt_reg, run_pcnt;
    logic        t1v_reg, run_t1v;
    logic [7:0]  t1_reg, run_t1;
    logic        t2v_reg, run_t2v;
    logic [7:0]  t2_reg, run_t2;
    logic        vv_reg, run_vv;
    logic [31:0] vexp_reg;

    logic        ov_reg;
    dec_word_t   out_reg;

    logic [7:0]  b;
    logic        esc_f;
    logic        esc_w;
    logic [2:0]  pfx_cnt;
    logic [4:0]  hex;
    logic [2:0]  tmc_k;
    logic [2:0]  r_cnt;
    logic        o_free;
    logic        pop;
    logic        accept;
    dec_word_t   head_word;
    logic [31:0] crc_pop;

    assign b = enc_word.data_byte;

    assign r_cnt  = (pcnt_reg - pidx_reg) + {2'b00, t1v_reg} + {2'b00, t2v_reg}
                  + {2'b00, vv_reg};
    assign o_free = !ov_reg || !dec_stall;
    assign pop    = o_free && (r_cnt != 3'd0);
    assign enc_stall = !((r_cnt == 3'd0) || ((r_cnt == 3'd1) && pop));
    assign accept = enc_valid && !enc_stall;

    assign dec_valid = ov_reg;
    assign dec_word  = out_reg;

    always_comb
    begin
        head_word = '0;
        if (pidx_reg < pcnt_reg)
        begin
            head_word.out_byte   = prefix_byte(pidx_reg);
            head_word.byte_valid = 1'b1;
        end
        else if (t1v_reg)
        begin
            head_word.out_byte   = t1_reg;
            head_word.byte_valid = 1'b1;
        end
        else if (t2v_reg)
        begin
            head_word.out_byte   = t2_reg;
            head_word.byte_valid = 1'b1;
        end
        else
        begin
            head_word.verdict_valid = vv_reg;
            head_word.computed_crc  = ~crc_reg;
            head_word.crc_ok        = (~crc_reg == vexp_reg);
        end
        head_word.last_of_run = (r_cnt == 3'd1);
        crc_pop = head_word.byte_valid ? crc32_byte(crc_reg, head_word.out_byte) : CRC_INIT;
    end

    always_comb
    begin
        phase_next = phase_reg;
        lmc_next   = lmc_reg;
        skip_next  = skip_reg;
        esc_next   = esc_reg;
        cr_next    = cr_reg;
        exp_next   = exp_reg;
        tmc_next   = tmc_reg;
        hdc_next   = hdc_reg;
        run_pcnt   = 3'd0;
        run_t1v    = 1'b0;
        run_t1     = 8'd0;
        run_t2v    = 1'b0;
        run_t2     = 8'd0;
        run_vv     = 1'b0;

        // A held line prefix that is flushed leaves an escape pending only when it
        // was the lone '='.
        esc_f   = skip_reg ? esc_reg : (lmc_reg == 4'd1);
        esc_w   = esc_f;
        pfx_cnt = (!skip_reg && lmc_reg >= 4'd2) ? 3'(lmc_reg - 4'd1) : 3'd0;
        hex     = hex_value(b);

        if (b == crc_char(tmc_reg))
        begin
            tmc_k = tmc_reg + 3'd1;
        end
        else if (tmc_reg == 3'd3 && b == crc_char(3'd1))
        begin
            tmc_k = 3'd2;
        end
        else if (b == crc_char(3'd0))
        begin
            tmc_k = 3'd1;
        end
        else
        begin
            tmc_k = 3'd0;
        end

        if (enc_word.end_of_input)
        begin
            if (phase_reg == PH_BODY)
            begin
                run_pcnt = pfx_cnt;
                if (cr_reg)
                begin
                    run_t1v = 1'b1;
                    run_t1  = decode_byte(BYTE_CR, esc_f);
                end
            end
            run_vv     = (phase_reg != PH_DONE);
            phase_next = PH_SEEK;
            lmc_next   = 4'd0;
            skip_next  = 1'b0;
            esc_next   = 1'b0;
            cr_next    = 1'b0;
            exp_next   = 32'd0;
            tmc_next   = 3'd0;
            hdc_next   = 4'd0;
        end
        else
        begin
            case (phase_reg)
                PH_SEEK:
                begin
                    if (b == BYTE_LF)
                    begin
                        lmc_next  = 4'd0;
                        skip_next = 1'b0;
                        esc_next  = 1'b0;
                        cr_next   = 1'b0;
                        if (lmc_reg == 4'(BEGIN_LEN))
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                    else if (!skip_reg && lmc_reg < 4'(BEGIN_LEN))
                    begin
                        if (b == begin_char(lmc_reg[2:0]))
                        begin
                            lmc_next = lmc_reg + 4'd1;
                        end
                        else
                        begin
                            skip_next = 1'b1;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (b == BYTE_LF)
                    begin
                        run_pcnt  = pfx_cnt;
                        lmc_next  = 4'd0;
                        skip_next = 1'b0;
                        esc_next  = 1'b0;
                        cr_next   = 1'b0;
                    end
                    else if (!skip_reg && lmc_reg < 4'(END_LEN)
                             && b == end_char(lmc_reg[2:0]))
                    begin
                        lmc_next = lmc_reg + 4'd1;
                        if (lmc_reg == 4'(END_LEN - 1))
                        begin
                            phase_next = PH_TRAIL;
                            tmc_next   = 3'd0;
                            hdc_next   = 4'd0;
                            exp_next   = 32'd0;
                        end
                    end
                    else
                    begin
                        run_pcnt  = pfx_cnt;
                        skip_next = 1'b1;
                        cr_next   = 1'b0;
                        if (cr_reg)
                        begin
                            run_t1v = 1'b1;
                            run_t1  = decode_byte(BYTE_CR, esc_f);
                            esc_w   = 1'b0;
                        end
                        if (b == BYTE_CR)
                        begin
                            cr_next  = 1'b1;
                            esc_next = esc_w;
                        end
                        else if (!esc_w && b == BYTE_ESC)
                        begin
                            esc_next = 1'b1;
                        end
                        else
                        begin
                            run_t2v  = 1'b1;
                            run_t2   = decode_byte(b, esc_w);
                            esc_next = 1'b0;
                        end
                    end
                end
                PH_TRAIL:
                begin
                    if (b == BYTE_LF)
                    begin
                        run_vv     = 1'b1;
                        phase_next = PH_DONE;
                        lmc_next   = 4'd0;
                        skip_next  = 1'b0;
                        esc_next   = 1'b0;
                        cr_next    = 1'b0;
                    end
                    else if (tmc_reg == 3'(TAG_LEN))
                    begin
                        if (!hex[4])
                        begin
                            tmc_next = 3'(TAG_LEN + 1);
                        end
                        else
                        begin
                            exp_next = {exp_reg[27:0], hex[3:0]};
                            hdc_next = hdc_reg + 4'd1;
                            if (hdc_reg >= 4'd7)
                            begin
                                tmc_next = 3'(TAG_LEN + 1);
                            end
                        end
                    end
                    else if (tmc_reg != 3'(TAG_LEN + 1))
                    begin
                        tmc_next = tmc_k;
                        if (tmc_k == 3'(TAG_LEN))
                        begin
                            exp_next = 32'd0;
                            hdc_next = 4'd0;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            lmc_reg   <= 4'd0;
            skip_reg  <= 1'b0;
            esc_reg   <= 1'b0;
            cr_reg    <= 1'b0;
            exp_reg   <= 32'd0;
            tmc_reg   <= 3'd0;
            hdc_reg   <= 4'd0;
            crc_reg   <= CRC_INIT;
            pidx_reg  <= 3'd0;
            pcnt_reg  <= 3'd0;
            t1v_reg   <= 1'b0;
            t1_reg    <= 8'd0;
            t2v_reg   <= 1'b0;
            t2_reg    <= 8'd0;
            vv_reg    <= 1'b0;
            vexp_reg  <= 32'd0;
            ov_reg    <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                lmc_reg   <= lmc_next;
                skip_reg  <= skip_next;
                esc_reg   <= esc_next;
                cr_reg    <= cr_next;
                exp_reg   <= exp_next;
                tmc_reg   <= tmc_next;
                hdc_reg   <= hdc_next;
                pidx_reg  <= 3'd0;
                pcnt_reg  <= run_pcnt;
                t1v_reg   <= run_t1v;
                t1_reg    <= run_t1;
                t2v_reg   <= run_t2v;
                t2_reg    <= run_t2;
                vv_reg    <= run_vv;
                vexp_reg  <= exp_reg;
            end
            else if (pop)
            begin
                if (pidx_reg < pcnt_reg)
                begin
                    pidx_reg <= pidx_reg + 3'd1;
                end
                else if (t1v_reg)
                begin
                    t1v_reg <= 1'b0;
                end
                else if (t2v_reg)
                begin
                    t2v_reg <= 1'b0;
                end
                else
                begin
                    vv_reg <= 1'b0;
                end
            end
            if (o_free)
            begin
                ov_reg <= pop;
                if (pop)
                begin
                    out_reg <= head_word;
                    crc_reg <= crc_pop;
                end
            end
        end
    end

endmodule

@@ sim/tb.sv @@
module tb;

    import yenc_dec_pkg::*;

    typedef enum logic [1:0] {
        SEEK_BEGIN,
        IN_BODY,
        IN_TRAILER,
        STREAM_DONE
    } parse_phase_t;

    typedef enum logic [1:0] {
        RX_SLOW,
        TX_SLOW,
        NO_IDLE
    } traffic_stage_t;

    localparam logic [63:0] BEGIN_TAG = "=ybegin ";
    localparam logic [63:0] END_TAG   = "=yend ";
    localparam logic [63:0] CRC_TAG   = "crc32=";
    localparam int          HOLD_CYCLES = 48;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      enc_valid = 1'b0;
    enc_word_t enc_word  = '0;
    logic      enc_stall;
    logic      dec_valid;
    logic      dec_stall = 1'b0;
    dec_word_t dec_word;

    enc_word_t pending_words[$];
    dec_word_t word_results[$];
    dec_word_t awaited_results[$];
    dec_word_t awaited;

    int stim_total      = 0;
    int words_accepted  = 0;
    int streams_built   = 0;
    int results_checked = 0;
    int verdicts_seen   = 0;
    int crc_matches     = 0;
    int error_count     = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;

    parse_phase_t dec_phase;
    int unsigned  line_match;
    bit           line_skip;
    bit           escape_held;
    bit           cr_held;
    logic [31:0]  running_crc;
    logic [31:0]  trailer_crc;
    int unsigned  keyword_match;
    int unsigned  hex_digits;

    yenc_stream_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_stall (enc_stall),
        .enc_word  (enc_word),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_word  (dec_word)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [7:0] char_of(logic [63:0] tag, int len, int idx);
        return tag[8 * (len - 1 - idx) +: 8];
    endfunction

    function automatic logic [31:0] crc_update(logic [31:0] crc, logic [7:0] data);
        logic feedback;
        for (int i = 0; i < 8; i++)
        begin
            feedback = crc[0] ^ data[i];
            crc = crc >> 1;
            if (feedback)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    function automatic int hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b - "0");
        if (b >= "a" && b <= "f")
            return int'(b - "a") + 10;
        if (b >= "A" && b <= "F")
            return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic traffic_stage_t current_stage();
        if (stim_total == 0 || words_accepted * 3 < stim_total)
            return RX_SLOW;
        if (words_accepted * 3 < stim_total * 2)
            return TX_SLOW;
        return NO_IDLE;
    endfunction

    function automatic int tx_idle_pct();
        case (current_stage())
            RX_SLOW: return 20;
            TX_SLOW: return 81;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct();
        case (current_stage())
            RX_SLOW: return 81;
            TX_SLOW: return 20;
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("tb: mismatch on result %0d: %s", results_checked, what);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Decoder state mirror.

    task automatic start_line();
        line_match  = 0;
        line_skip   = 1'b0;
        escape_held = 1'b0;
        cr_held     = 1'b0;
    endtask

    task automatic restart_decoder();
        dec_phase     = SEEK_BEGIN;
        start_line();
        running_crc   = CRC_INIT;
        trailer_crc   = '0;
        keyword_match = 0;
        hex_digits    = 0;
    endtask

    task automatic add_result(logic [7:0] b, bit is_byte, bit is_verdict, bit ok,
                              logic [31:0] crc);
        dec_word_t r;
        if (word_results.size() >= 8)
            return;
        r.out_byte      = b;
        r.byte_valid    = is_byte;
        r.verdict_valid = is_verdict;
        r.crc_ok        = ok;
        r.computed_crc  = crc;
        r.last_of_run   = 1'b0;
        word_results.push_back(r);
    endtask

    task automatic emit_decoded(logic [7:0] v);
        running_crc = crc_update(running_crc, v);
        add_result(v, 1'b1, 1'b0, 1'b0, '0);
    endtask

    task automatic emit_verdict();
        logic [31:0] fin;
        fin = ~running_crc;
        add_result('0, 1'b0, 1'b1, fin == trailer_crc, fin);
    endtask

    task automatic decode_char(logic [7:0] x);
        if (escape_held)
        begin
            escape_held = 1'b0;
            emit_decoded(x - OFFSET_ESC - OFFSET_BASE);
        end
        else if (x == BYTE_ESC)
            escape_held = 1'b1;
        else
            emit_decoded(x - OFFSET_BASE);
    endtask

    task automatic body_char(logic [7:0] b);
        if (cr_held)
        begin
            cr_held = 1'b0;
            decode_char(BYTE_CR);
        end
        if (b == BYTE_CR)
            cr_held = 1'b1;
        else
            decode_char(b);
    endtask

    // A held line start that did not become a trailer tag is decoded as data.
    task automatic release_prefix();
        if (!line_skip)
        begin
            for (int i = 0; i < line_match && i < 6; i++)
                decode_char(char_of(END_TAG, 6, i));
            line_skip = 1'b1;
        end
    endtask

    task automatic trailer_char(logic [7:0] b);
        int k;
        int v;
        k = keyword_match;
        if (k == 7)
            return;
        if (k == 6)
        begin
            v = hex_digit(b);
            if (v < 0)
            begin
                keyword_match = 7;
                return;
            end
            trailer_crc = {trailer_crc[27:0], v[3:0]};
            hex_digits++;
            if (hex_digits >= 8)
                keyword_match = 7;
            return;
        end
        while (k > 0 && char_of(CRC_TAG, 6, k) != b)
            k = (k == 3) ? 1 : 0;
        if (char_of(CRC_TAG, 6, k) == b)
            k++;
        keyword_match = k;
        if (k == 6)
        begin
            trailer_crc = '0;
            hex_digits  = 0;
        end
    endtask

    task automatic decode_word(enc_word_t w);
        logic [7:0] b;
        bit         header_seen;
        dec_word_t  r;
        b = w.data_byte;
        word_results.delete();
        if (w.end_of_input)
        begin
            if (dec_phase == IN_BODY)
            begin
                release_prefix();
                if (cr_held)
                begin
                    cr_held = 1'b0;
                    decode_char(BYTE_CR);
                end
            end
            if (dec_phase != STREAM_DONE)
                emit_verdict();
            restart_decoder();
        end
        else
        begin
            case (dec_phase)
                SEEK_BEGIN:
                begin
                    if (b == BYTE_LF)
                    begin
                        header_seen = (line_match == 8);
                        start_line();
                        if (header_seen)
                            dec_phase = IN_BODY;
                    end
                    else if (!line_skip && line_match < 8)
                    begin
                        if (b == char_of(BEGIN_TAG, 8, line_match))
                            line_match++;
                        else
                            line_skip = 1'b1;
                    end
                end
                IN_BODY:
                begin
                    if (b == BYTE_LF)
                    begin
                        release_prefix();
                        start_line();
                    end
                    else if (!line_skip && line_match < 6 &&
                             b == char_of(END_TAG, 6, line_match))
                    begin
                        line_match++;
                        if (line_match == 6)
                        begin
                            dec_phase     = IN_TRAILER;
                            keyword_match = 0;
                            hex_digits    = 0;
                            trailer_crc   = '0;
                        end
                    end
                    else
                    begin
                        release_prefix();
                        body_char(b);
                    end
                end
                IN_TRAILER:
                begin
                    if (b == BYTE_LF)
                    begin
                        emit_verdict();
                        dec_phase = STREAM_DONE;
                        start_line();
                    end
                    else
                        trailer_char(b);
                end
                default:
                begin
                end
            endcase
        end
        if (word_results.size() > 0)
        begin
            r = word_results[$];
            r.last_of_run = 1'b1;
            word_results[word_results.size() - 1] = r;
        end
        foreach (word_results[i])
            awaited_results.push_back(word_results[i]);
    endtask

    // Stimulus construction.

    task automatic send_byte(logic [7:0] b);
        enc_word_t w;
        w.data_byte    = b;
        w.end_of_input = 1'b0;
        pending_words.push_back(w);
    endtask

    task automatic send_end();
        enc_word_t w;
        w.data_byte    = 8'($urandom_range(0, 255));
        w.end_of_input = 1'b1;
        pending_words.push_back(w);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_payload_byte(logic [7:0] d);
        logic [7:0] e;
        logic [7:0] shifted;
        e       = d + OFFSET_BASE;
        shifted = e + OFFSET_ESC;
        if (e == 8'h00 || e == BYTE_LF || e == BYTE_CR || e == BYTE_ESC ||
            ($urandom_range(0, 29) == 0 && shifted != BYTE_LF && shifted != BYTE_CR))
        begin
            send_byte(BYTE_ESC);
            send_byte(shifted);
        end
        else
            send_byte(e);
    endtask

    task automatic send_line_noise();
        case ($urandom_range(0, 3))
            0: send_text("=ye");
            1: send_text("=yend\n");
            2: send_byte(BYTE_CR);
            default:
            begin
                send_byte(BYTE_ESC);
                send_byte(BYTE_LF);
            end
        endcase
    endtask

    task automatic build_stream();
        int          n;
        int          pos;
        int          len;
        logic [31:0] crc;
        logic [7:0]  b;
        string       trailer_line;
        repeat ($urandom_range(0, 2))
        begin
            repeat ($urandom_range(0, 5))
            begin
                b = 8'($urandom_range(0, 255));
                send_byte(b == BYTE_LF ? ~b : b);
            end
            send_byte(BYTE_LF);
        end
        if ($urandom_range(0, 3) == 0)
            send_text("=ybeg\n");
        send_text("=ybegin n\n");
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 48) : $urandom_range(0, 16);
        crc = CRC_INIT;
        pos = 0;
        while (pos < n)
        begin
            if ($urandom_range(0, 7) == 0)
                send_line_noise();
            len = $urandom_range(1, 8);
            for (int j = 0; j < len && pos < n; j++)
            begin
                b   = 8'($urandom_range(0, 255));
                crc = crc_update(crc, b);
                send_payload_byte(b);
                pos++;
            end
            if ($urandom_range(0, 2) == 0)
                send_byte(BYTE_CR);
            send_byte(BYTE_LF);
        end
        case ($urandom_range(0, 9))
            5: trailer_line = $sformatf("=yend size=%0d crc32=%08Xab\n", n, ~crc);
            6: trailer_line = $sformatf("=yend crc32=%08x\n",
                                        ~crc ^ (32'd1 << $urandom_range(0, 31)));
            7: trailer_line = $sformatf("=yend crcrc32=%0h z\n", $urandom_range(0, 4095));
            8: trailer_line = ($urandom_range(0, 1) == 0) ? "=yend size=0\n" : "=yend size";
            9: trailer_line = "";
            default: trailer_line = $sformatf("=yend size=%0d crc32=%08x\n", n, ~crc);
        endcase
        if (trailer_line.len() == 0)
        begin
            case ($urandom_range(0, 3))
                1: send_text("=y");
                2:
                begin
                    send_byte("A");
                    send_byte(BYTE_CR);
                end
                3:
                begin
                    send_byte("A");
                    send_byte(BYTE_ESC);
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            send_text(trailer_line);
            repeat ($urandom_range(0, 3))
                send_byte(8'($urandom_range(0, 255)));
        end
        send_end();
        streams_built++;
    endtask

    // Sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_valid <= 1'b0;
            enc_word  <= '0;
        end
        else
        begin
            if (enc_valid && !enc_stall)
            begin
                decode_word(enc_word);
                words_accepted <= words_accepted + 1;
            end
            if (!enc_valid || !enc_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct())
                begin
                    enc_valid <= 1'b1;
                    enc_word  <= pending_words.pop_front();
                end
                else
                    enc_valid <= 1'b0;
            end
        end
    end

    // Receiver, with one long hold-off once the no-idle stretch begins.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (!hold_done && current_stage() == NO_IDLE)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            dec_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_idle_pct());
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dec_valid && !dec_stall)
        begin
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h", dec_word));
            else
            begin
                awaited = awaited_results.pop_front();
                compare_field("out_byte", dec_word.out_byte, awaited.out_byte);
                compare_field("byte_valid", dec_word.byte_valid, awaited.byte_valid);
                compare_field("verdict_valid", dec_word.verdict_valid, awaited.verdict_valid);
                compare_field("crc_ok", dec_word.crc_ok, awaited.crc_ok);
                compare_field("computed_crc", dec_word.computed_crc, awaited.computed_crc);
                compare_field("last_of_run", dec_word.last_of_run, awaited.last_of_run);
                results_checked++;
                if (awaited.verdict_valid)
                begin
                    verdicts_seen++;
                    if (awaited.crc_ok)
                        crc_matches++;
                end
            end
        end
    end

    initial
    begin
        restart_decoder();
        // End of input with no begin line, then a short body with the edge cases.
        send_end();
        send_text("=ybegin \n");
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(BYTE_ESC);
        send_byte(8'h80);
        send_byte(BYTE_CR);
        send_byte("x");
        send_byte(BYTE_ESC);
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
        send_text("=ye");
        send_end();
        send_end();
        while (pending_words.size() < 400)
            build_stream();
        stim_total = pending_words.size();

        wait (words_accepted == stim_total);
        wait (awaited_results.size() == 0);
        repeat (10) @(posedge clk);
        $display("tb: %0d words in %0d streams sent, %0d results checked",
                 stim_total, streams_built, results_checked);
        $display("tb: %0d verdicts seen, %0d with matching crc, %0d mismatches",
                 verdicts_seen, crc_matches, error_count);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: timeout with %0d results still awaited", awaited_results.size());
        $display("tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/yenc_dec_pkg.sv
rtl/yenc_stream_decoder.sv
sim/tb.sv
